// File: hw/rtl/bds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg
// Shared constants for the 2x2 box-filter downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int MaxWidthDef  = 4096;
  localparam int ChannelsDef  = 4;
  localparam int MaxHeight    = 4096;
  localparam int RowW         = 12;
  localparam int PixW         = 8;
  localparam int SumW         = PixW + 1;
  localparam int CfgW         = 13;
  localparam int DataW        = 32;
  localparam int AddrW        = 3;

  localparam logic [CfgW-1:0] DimReset = 13'd4096;

  localparam logic RegSrcWidth  = 1'b0;
  localparam logic RegSrcHeight = 1'b1;

endpackage

// File: hw/rtl/bds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bds_ram #(
  parameter int Width = 36,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/box_downsample_2x2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_2x2
// Halves an RGBA8 raster stream by averaging each 2x2 block of pixels.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock. The input waits only while the result
// register and the read stage before it both hold results and the result
// side is not ready; any pixel waits then, whether it completes a block or not.
// A result for the pixel that completes its 2x2 block (odd row, odd column)
// passes through the registered read of the line store, then the output
// register. The line store is a MAX_WIDTH/2 deep RAM of horizontal pair sums
// (9 bits per channel) with one write and one read port; it needs no
// clearing pass, since each entry is written on an even row before the odd
// row reads it. Writing either size register restarts the frame. Odd last
// column or row pixels are taken and dropped.
// ----------------------------------------------------------------------------
module box_downsample_2x2 #(
  parameter int MAX_WIDTH = bds_pkg::MaxWidthDef,
  parameter int CHANNELS  = bds_pkg::ChannelsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB config
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bds_pkg::AddrW-1:0]  paddr,
  input  logic [bds_pkg::DataW-1:0]  pwdata,
  output logic [bds_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  // source pixels
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
  // half-size pixels
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                       m_axis_tlast   // frame_last
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = bds_pkg::RowW;
  localparam int Depth = MAX_WIDTH / 2;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = bds_pkg::PixW;
  localparam int SW    = bds_pkg::SumW;
  localparam int LW    = SW * CHANNELS;
  localparam int WEW   = (CW + 1 > bds_pkg::CfgW) ? CW + 1 : bds_pkg::CfgW;
  localparam int WRst  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int WRstU = (WRst / 2) * 2;

  // config registers
  logic [bds_pkg::CfgW-1:0] cfg_w_q, cfg_h_q;
  logic [CW-1:0]            w_m1_q, uw_m1_q;
  logic [RW-1:0]            h_m1_q, uh_m1_q;
  logic                     w_odd_q, h_odd_q;

  logic                     cfg_we;
  logic [bds_pkg::CfgW-1:0] cfg_val;
  logic [WEW-1:0]           wv_ext, w_eff;
  logic [bds_pkg::CfgW-1:0] h_eff;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_val = pwdata[bds_pkg::CfgW-1:0];
  assign wv_ext  = WEW'(cfg_val);

  always_comb begin
    priority if (wv_ext < WEW'(2)) begin
      w_eff = WEW'(2);
    end else if (wv_ext > WEW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = wv_ext;
    end
    priority if (cfg_val < bds_pkg::CfgW'(2)) begin
      h_eff = bds_pkg::CfgW'(2);
    end else if (cfg_val > bds_pkg::CfgW'(bds_pkg::MaxHeight)) begin
      h_eff = bds_pkg::CfgW'(bds_pkg::MaxHeight);
    end else begin
      h_eff = cfg_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= bds_pkg::DimReset;
      cfg_h_q <= bds_pkg::DimReset;
      w_m1_q  <= CW'(WRst - 1);
      uw_m1_q <= CW'(WRstU - 1);
      w_odd_q <= 1'(WRst % 2);
      h_m1_q  <= RW'(bds_pkg::MaxHeight - 1);
      uh_m1_q <= RW'(bds_pkg::MaxHeight - 1);
      h_odd_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        bds_pkg::RegSrcWidth: begin
          cfg_w_q <= cfg_val;
          w_m1_q  <= CW'(w_eff - WEW'(1));
          uw_m1_q <= CW'({w_eff[WEW-1:1], 1'b0} - WEW'(1));
          w_odd_q <= w_eff[0];
        end
        bds_pkg::RegSrcHeight: begin
          cfg_h_q <= cfg_val;
          h_m1_q  <= RW'(h_eff - bds_pkg::CfgW'(1));
          uh_m1_q <= RW'({h_eff[bds_pkg::CfgW-1:1], 1'b0} - bds_pkg::CfgW'(1));
          h_odd_q <= h_eff[0];
        end
        default: begin
          cfg_w_q <= cfg_w_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bds_pkg::RegSrcWidth:  prdata = bds_pkg::DataW'(cfg_w_q);
      bds_pkg::RegSrcHeight: prdata = bds_pkg::DataW'(cfg_h_q);
      default:               prdata = '0;
    endcase
  end

  // handshake and pipeline control
  logic s1_valid_q, s1_last_q, m_valid_q, m_last_q;
  logic [LW-1:0] s1_ps_q;
  logic [31:0]   m_data_q;
  logic out_free, s_fire;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // position counters
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic col_last, row_last, in_used, produce, frame_last_d;

  assign col_last     = (col_q == w_m1_q);
  assign row_last     = (row_q == h_m1_q);
  assign in_used      = !(col_last && w_odd_q) && !(row_last && h_odd_q);
  assign produce      = s_fire && in_used && col_q[0] && row_q[0];
  assign frame_last_d = (col_q == uw_m1_q) && (row_q == uh_m1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we) begin
      col_q <= '0;
      row_q <= '0;
    end else if (s_fire) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // held even-column pixel and horizontal pair sums
  logic [PW-1:0] held_q [CHANNELS];
  logic [LW-1:0] ps_d;
  logic [LW-1:0] above;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      ps_d[c*SW +: SW] = SW'(held_q[c]) + SW'(s_axis_tdata[c*PW +: PW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        held_q[c] <= '0;
      end
    end else if (s_fire && in_used && !col_q[0]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        held_q[c] <= s_axis_tdata[c*PW +: PW];
      end
    end
  end

  bds_ram #(
    .Width (LW),
    .Depth (Depth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s_fire && in_used && col_q[0] && !row_q[0]),
    .waddr_i (AW'(col_q >> 1)),
    .wdata_i (ps_d),
    .re_i    (produce),
    .raddr_i (AW'(col_q >> 1)),
    .rdata_o (above)
  );

  // stage 1: pair sum of the odd row waits for the line store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      s1_ps_q   <= ps_d;
      s1_last_q <= frame_last_d;
    end
  end

  // output register
  logic [31:0] avg_d;

  always_comb begin
    logic [SW:0] tot;
    avg_d = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      tot = (SW+1)'(above[c*SW +: SW]) + (SW+1)'(s1_ps_q[c*SW +: SW]);
      avg_d[c*PW +: PW] = tot[SW:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      m_data_q <= avg_d;
      m_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // checks
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("stage 1 result dropped while output stalled");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_m1_q)
    else $error("column count beyond source width");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_m1_q)
    else $error("row count beyond source height");

endmodule
